/* rtl/core/esr_pkg.sv */
// Shared types, symbol codes and character decode for the expression recognizer.
package esr_pkg;

  localparam int SYM_W = 3;

  localparam logic [SYM_W-1:0] SYM_OTHER = 3'd0;
  localparam logic [SYM_W-1:0] SYM_I     = 3'd1;
  localparam logic [SYM_W-1:0] SYM_D     = 3'd2;
  localparam logic [SYM_W-1:0] SYM_E     = 3'd3;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 3'd4;
  localparam logic [SYM_W-1:0] SYM_STAR  = 3'd5;
  localparam logic [SYM_W-1:0] SYM_LPAR  = 3'd6;
  localparam logic [SYM_W-1:0] SYM_RPAR  = 3'd7;

  localparam logic [7:0] CHR_I    = 8'h69;
  localparam logic [7:0] CHR_D    = 8'h64;
  localparam logic [7:0] CHR_E    = 8'h45;
  localparam logic [7:0] CHR_PLUS = 8'h2B;
  localparam logic [7:0] CHR_STAR = 8'h2A;
  localparam logic [7:0] CHR_LPAR = 8'h28;
  localparam logic [7:0] CHR_RPAR = 8'h29;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } esr_in_t;

  typedef struct packed {
    logic [7:0] depth_after;
    logic [7:0] reductions;
    logic       overflowed;
    logic       string_done;
    logic       accepted;
  } esr_out_t;

  typedef struct packed {
    logic [SYM_W-1:0] code;
    logic             last;
  } esr_sym_t;

  function automatic logic [SYM_W-1:0] encode_symbol(input logic [7:0] ch);
    logic [SYM_W-1:0] code;
    unique case (ch)
      CHR_I:    code = SYM_I;
      CHR_D:    code = SYM_D;
      CHR_E:    code = SYM_E;
      CHR_PLUS: code = SYM_PLUS;
      CHR_STAR: code = SYM_STAR;
      CHR_LPAR: code = SYM_LPAR;
      CHR_RPAR: code = SYM_RPAR;
      default:  code = SYM_OTHER;
    endcase
    return code;
  endfunction

endpackage

/* rtl/core/esr_front.sv */
// Front end: accept characters, decode them to symbol codes and queue them.
module esr_front
  import esr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  esr_in_t  in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output esr_sym_t q_data
);

  esr_sym_t           q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               push, pop;

  assign in_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_data   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Decode on entry so the back end sees only symbol codes.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r].code <= encode_symbol(in_data.symbol);
      q_mem_r[wr_ptr_r].last <= in_data.last;
    end
  end

endmodule

/* rtl/core/esr_stack.sv */
// Back end: symbol stack, handle reduction sequencer and result register.
module esr_stack
  import esr_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  output logic     q_ready,
  input  esr_sym_t q_data,
  output logic     out_valid,
  input  logic     out_ready,
  output esr_out_t out_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int XW = (CW > 8) ? CW : 8;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_CHECK   = 2'd1;
  localparam logic [1:0] ST_FILL_HI = 2'd2;
  localparam logic [1:0] ST_FILL_LO = 2'd3;

  logic [SYM_W-1:0] stack_mem [STACK_DEPTH];
  logic [SYM_W-1:0] rd_data_r;

  logic [1:0]       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       reds_r, reds_nxt;
  logic             last_r, last_nxt;
  // Window on the top three entries: w0 is the top of stack.
  logic [SYM_W-1:0] w0_r, w0_nxt, w1_r, w1_nxt, w2_r, w2_nxt;
  logic             out_valid_r, out_valid_nxt;
  esr_out_t         out_data_r, out_data_nxt;

  logic             mem_we;
  logic [AW-1:0]    wr_addr;
  logic [SYM_W-1:0] wr_data;
  logic [CW-1:0]    rd_idx;
  logic [AW-1:0]    rd_addr;

  logic             m2, m3, out_free, load;
  logic [XW-1:0]    cnt_x;
  logic [7:0]       depth_sat;

  assign m2 = (count_r >= CW'(2)) && (w1_r == SYM_I) && (w0_r == SYM_D);
  assign m3 = (count_r >= CW'(3)) &&
              (((w2_r == SYM_E) && ((w1_r == SYM_PLUS) || (w1_r == SYM_STAR)) &&
                (w0_r == SYM_E)) ||
               ((w2_r == SYM_LPAR) && (w1_r == SYM_E) && (w0_r == SYM_RPAR)));

  assign out_free  = !out_valid_r || out_ready;
  assign load      = (state_r == ST_CHECK) && !m2 && !m3 && out_free;
  assign cnt_x     = XW'(count_r);
  assign depth_sat = (cnt_x > XW'(255)) ? 8'hFF : cnt_x[7:0];

  // Refill address: two (i d) or one (3-symbol) below the new top in the check
  // cycle, the next one below in the high-fill cycle.
  assign rd_idx  = (state_r == ST_CHECK) ? count_r - CW'(4) : count_r - CW'(3);
  assign rd_addr = rd_idx[AW-1:0];

  assign q_ready   = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    reds_nxt      = reds_r;
    last_nxt      = last_r;
    w0_nxt        = w0_r;
    w1_nxt        = w1_r;
    w2_nxt        = w2_r;
    mem_we        = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = q_data.code;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          last_nxt  = q_data.last;
          reds_nxt  = '0;
          state_nxt = ST_CHECK;
          if (count_r != CW'(STACK_DEPTH)) begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
            w0_nxt    = q_data.code;
            w1_nxt    = w0_r;
            w2_nxt    = w1_r;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        priority if (m2) begin
          count_nxt = count_r - 1'b1;
          wr_addr   = rd_idx[AW-1:0] + AW'(2);
          wr_data   = SYM_E;
          mem_we    = 1'b1;
          w0_nxt    = SYM_E;
          w1_nxt    = w2_r;
          reds_nxt  = (reds_r == 8'hFF) ? reds_r : reds_r + 1'b1;
          state_nxt = ST_FILL_LO;
        end else if (m3) begin
          count_nxt = count_r - CW'(2);
          wr_addr   = rd_idx[AW-1:0] + AW'(1);
          wr_data   = SYM_E;
          mem_we    = 1'b1;
          w0_nxt    = SYM_E;
          reds_nxt  = (reds_r == 8'hFF) ? reds_r : reds_r + 1'b1;
          state_nxt = ST_FILL_HI;
        end else if (load) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.depth_after = depth_sat;
          out_data_nxt.reductions  = reds_r;
          out_data_nxt.overflowed  = ovf_r;
          out_data_nxt.string_done = last_r;
          out_data_nxt.accepted    = last_r && !ovf_r && (count_r == CW'(1)) &&
                                     (w0_r == SYM_E);
          if (last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_FILL_HI: begin
        w1_nxt    = rd_data_r;
        state_nxt = ST_FILL_LO;
      end
      ST_FILL_LO: begin
        w2_nxt    = rd_data_r;
        state_nxt = ST_CHECK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    reds_r     <= reds_nxt;
    last_r     <= last_nxt;
    w0_r       <= w0_nxt;
    w1_r       <= w1_nxt;
    w2_r       <= w2_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= stack_mem[rd_addr];
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_r) |=> (count_r == '0) && !ovf_r)
    else $error("stack not cleared after closing a string");

  a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL_HI) |=> (state_r == ST_FILL_LO))
    else $error("window refill out of order");

  a_accept_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.accepted || out_data_r.string_done))
    else $error("accept flagged outside string end");
`endif

endmodule

/* rtl/core/expression_shift_reduce_recognizer_core.sv */
// Result path: the input is queued, pushed onto the stack and checked; the
// result register loads once free. Each reduction runs low fill (i d handle)
// or high then low fill (three-symbol handle) and returns to check. The stack
// sequencer, with its single memory read port, takes new symbols only in idle.
// Reset: rst_n, synchronous and active low, empties queue and stack and drops
// any pending result; stack memory contents are never cleared.
module expression_shift_reduce_recognizer_core
  import esr_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  esr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output esr_out_t out_data
);

  // Decoded symbols waiting for the stack engine. The queue lets the input
  // side keep taking characters while a reduction chain is in progress.
  logic     q_valid;
  logic     q_ready;
  esr_sym_t q_data;

  // Front end: decode each character to a symbol code on transfer and hold it
  // in a short queue.
  esr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  // Back end: push the symbol, reduce greedily one handle per step while the
  // top of stack matches, then load the result register. The top three
  // entries live in a register window; the memory refills it after a pop.
  // A push into a full stack is dropped and sets the sticky overflow flag;
  // a closing item gives the verdict, then clears the stack and the flag.
  esr_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
